/* design/tga_pkg.sv */
// Package for the Targa run-length pixel decoder: types, constants and small
// helper functions shared by the front end, command queue and back end.
// No dependencies.
`default_nettype none

package tga_pkg;

    // Palette store and packet limits
    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam int MAX_RUN       = 128;

    // Queue depths between the parts and on the result side
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    // Configuration register indexes
    localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd0;
    localparam logic [1:0] CFG_RLE_ENABLE   = 2'd1;
    localparam logic [1:0] CFG_PIXEL_TOTAL  = 2'd2;

    // Input item kinds
    localparam logic FUNC_STREAM  = 1'b0;
    localparam logic FUNC_PALETTE = 1'b1;

    // Reset values of the configuration registers
    localparam logic [2:0]  RST_PIXEL_FORMAT = 3'd2;
    localparam logic        RST_RLE_ENABLE   = 1'b0;
    localparam logic [24:0] RST_PIXEL_TOTAL  = 25'd1;

    typedef enum logic [2:0] {
        FMT_INDEXED8 = 3'd0,
        FMT_RGB555   = 3'd1,
        FMT_RGB24    = 3'd2,
        FMT_RGBA32   = 3'd3,
        FMT_GRAY8    = 3'd4,
        FMT_GRAY16   = 3'd5
    } t_fmt;

    // One command from the front end: a palette write or a finished pixel
    typedef struct packed {
        logic        wr;
        logic [2:0]  fmt;
        logic [31:0] data;
        logic [7:0]  idx;
        logic [7:0]  rep;
        logic        last;
    } t_cmd;

    // One decoded result
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [2:0] nbytes;
        logic [7:0] rep;
        logic       last;
    } t_pix;

    // Stream bytes per pixel; unused codes behave as 24-bit
    function automatic logic [2:0] bytes_in(input logic [2:0] fmt);
        logic [2:0] n;
        unique case (t_fmt'(fmt))
            FMT_INDEXED8: n = 3'd1;
            FMT_RGB555:   n = 3'd2;
            FMT_RGB24:    n = 3'd3;
            FMT_RGBA32:   n = 3'd4;
            FMT_GRAY8:    n = 3'd1;
            FMT_GRAY16:   n = 3'd2;
            default:      n = 3'd3;
        endcase
        return n;
    endfunction

    function automatic logic pal_in_range(input logic [7:0] idx);
        return ({1'b0, idx} < 9'(PALETTE_DEPTH));
    endfunction

endpackage

`default_nettype wire

/* design/tga_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tga_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* design/tga_fe.sv */
// Front end: configuration registers, packet header parsing, byte gathering
// and pixel counting. Emits one command per palette write or finished pixel.
// Depends on tga_pkg.
`default_nettype none

module tga_fe (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_idx,
    input  wire logic [24:0]          i_cfg_data,
    input  wire logic                 i_push,
    input  wire logic                 i_qfull,
    input  wire logic                 i_func,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic [7:0]           i_palette_index,
    input  wire logic [23:0]          i_palette_color,
    output logic                      o_cmd_valid,
    output tga_pkg::t_cmd             o_cmd
);

    logic [2:0]  r_fmt;
    logic        r_rle;
    logic [24:0] r_total;

    logic        r_run,  n_run;
    logic [7:0]  r_left, n_left;
    logic [1:0]  r_pos,  n_pos;
    logic [23:0] r_gath, n_gath;
    logic [24:0] r_done, n_done;

    logic        accept;
    logic [25:0] diff;
    logic        img_done;
    logic [24:0] remaining;
    logic [2:0]  need;
    logic [31:0] t;
    logic [7:0]  rep_raw;
    logic [7:0]  rep_c;
    logic        rep_last;

    assign accept    = i_push && !i_qfull;
    assign diff      = {1'b0, r_total} - {1'b0, r_done};
    assign img_done  = diff[25] || (diff == 26'd0);
    assign remaining = diff[24:0];
    assign need      = tga_pkg::bytes_in(r_fmt);
    assign t         = {8'h00, r_gath} | (32'(i_data_byte) << {r_pos, 3'b000});
    assign rep_raw   = (r_rle && r_run) ? r_left : 8'd1;
    assign rep_c     = ({17'd0, rep_raw} > remaining) ? remaining[7:0] : rep_raw;
    assign rep_last  = ({17'd0, rep_raw} >= remaining);

    always_comb begin
        n_run       = r_run;
        n_left      = r_left;
        n_pos       = r_pos;
        n_gath      = r_gath;
        n_done      = r_done;
        o_cmd_valid = 1'b0;
        o_cmd.wr    = 1'b0;
        o_cmd.fmt   = r_fmt;
        o_cmd.data  = t;
        o_cmd.idx   = i_palette_index;
        o_cmd.rep   = rep_c;
        o_cmd.last  = rep_last;
        if (accept) begin
            priority if (i_func == tga_pkg::FUNC_PALETTE) begin
                // drop writes beyond the palette
                o_cmd_valid = tga_pkg::pal_in_range(i_palette_index);
                o_cmd.wr    = 1'b1;
                o_cmd.data  = {8'h00, i_palette_color};
            end else if (img_done) begin
                // image complete: ignore stream bytes
            end else if (r_rle && (r_left == 8'd0)) begin
                n_run  = i_data_byte[7];
                n_left = {1'b0, i_data_byte[6:0]} + 8'd1;
                n_pos  = 2'd0;
                n_gath = 24'd0;
            end else if (({1'b0, r_pos} + 3'd1) < need) begin
                n_gath = t[23:0];
                n_pos  = r_pos + 2'd1;
            end else begin
                n_pos       = 2'd0;
                n_gath      = 24'd0;
                n_done      = r_done + {17'd0, rep_c};
                o_cmd_valid = 1'b1;
                if (r_rle && r_run) begin
                    n_left = 8'd0;
                end else if (r_rle) begin
                    n_left = r_left - 8'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt   <= tga_pkg::RST_PIXEL_FORMAT;
            r_rle   <= tga_pkg::RST_RLE_ENABLE;
            r_total <= tga_pkg::RST_PIXEL_TOTAL;
            r_run   <= 1'b0;
            r_left  <= 8'd0;
            r_pos   <= 2'd0;
            r_gath  <= 24'd0;
            r_done  <= 25'd0;
        end else begin
            r_run  <= n_run;
            r_left <= n_left;
            r_pos  <= n_pos;
            r_gath <= n_gath;
            r_done <= n_done;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tga_pkg::CFG_PIXEL_FORMAT: r_fmt   <= i_cfg_data[2:0];
                    tga_pkg::CFG_RLE_ENABLE:   r_rle   <= i_cfg_data[0];
                    tga_pkg::CFG_PIXEL_TOTAL:  r_total <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    a_left_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= 8'(tga_pkg::MAX_RUN))
        else $error("packet count above the longest packet");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_valid |-> !i_qfull)
        else $error("command issued into a full queue");
    a_no_pixel_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (img_done && o_cmd_valid) |-> o_cmd.wr)
        else $error("pixel issued after the image was complete");
`endif

endmodule

`default_nettype wire

/* design/tga_cmdq.sv */
// Short command queue between the front end and the back end.
// Depends on tga_pkg.
`default_nettype none

module tga_cmdq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tga_pkg::t_cmd i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output tga_pkg::t_cmd      o_data
);

    tga_pkg::t_cmd                 r_mem [tga_pkg::CMDQ_DEPTH];
    logic [tga_pkg::CMDQ_PW-1:0]   r_wp, n_wp;
    logic [tga_pkg::CMDQ_PW-1:0]   r_rp, n_rp;
    logic [tga_pkg::CMDQ_CW-1:0]   r_cnt, n_cnt;
    logic                          do_push;
    logic                          do_pop;

    assign o_full  = (r_cnt == tga_pkg::CMDQ_CW'(tga_pkg::CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == tga_pkg::CMDQ_PW'(tga_pkg::CMDQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == tga_pkg::CMDQ_PW'(tga_pkg::CMDQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

/* design/tga_be.sv */
// Back end: carries out palette writes, looks up palette colours, assembles
// output bytes per format and holds results in an output queue.
// Depends on tga_pkg and tga_ram.
`default_nettype none

module tga_be (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_empty,
    input  wire tga_pkg::t_cmd i_q_data,
    output logic               o_q_pop,
    input  wire logic          i_pop,
    output logic               o_empty,
    output tga_pkg::t_pix      o_pix
);

    logic                          r_s1_valid;
    tga_pkg::t_cmd                 r_s1;
    logic                          r_s1_inr;
    logic [23:0]                   pal_rdata;
    logic [23:0]                   colour;
    logic                          room;
    logic                          ram_we;
    tga_pkg::t_pix                 dec;

    tga_pkg::t_pix                 r_oq [tga_pkg::OUTQ_DEPTH];
    logic [tga_pkg::OUTQ_PW-1:0]   r_wp, n_wp;
    logic [tga_pkg::OUTQ_PW-1:0]   r_rp, n_rp;
    logic [tga_pkg::OUTQ_CW-1:0]   r_cnt, n_cnt;
    logic                          oq_pop;

    // reserve a slot for the pixel already in flight
    assign room = ((tga_pkg::OUTQ_CW + 1)'(r_cnt) + (tga_pkg::OUTQ_CW + 1)'(r_s1_valid))
                  < (tga_pkg::OUTQ_CW + 1)'(tga_pkg::OUTQ_DEPTH);
    assign o_q_pop = !i_q_empty && room;
    assign ram_we  = o_q_pop && i_q_data.wr;

    tga_ram #(
        .WIDTH (24),
        .DEPTH (tga_pkg::PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_q_data.idx[tga_pkg::PAL_AW-1:0]),
        .i_wdata (i_q_data.data[23:0]),
        .i_raddr (i_q_data.data[tga_pkg::PAL_AW-1:0]),
        .o_rdata (pal_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1     <= i_q_data;
            r_s1_inr <= tga_pkg::pal_in_range(i_q_data.data[7:0]);
        end
    end

    assign colour = r_s1_inr ? pal_rdata : 24'd0;

    always_comb begin
        dec.b0     = 8'd0;
        dec.b1     = 8'd0;
        dec.b2     = 8'd0;
        dec.b3     = 8'd0;
        dec.nbytes = 3'd3;
        dec.rep    = r_s1.rep;
        dec.last   = r_s1.last;
        unique case (tga_pkg::t_fmt'(r_s1.fmt))
            tga_pkg::FMT_INDEXED8: begin
                dec.b0 = colour[23:16];
                dec.b1 = colour[15:8];
                dec.b2 = colour[7:0];
            end
            tga_pkg::FMT_RGB555: begin
                dec.b0 = {r_s1.data[14:10], 3'b000};
                dec.b1 = {r_s1.data[9:5], 3'b000};
                dec.b2 = {r_s1.data[4:0], 3'b000};
            end
            tga_pkg::FMT_RGBA32: begin
                dec.b0     = r_s1.data[23:16];
                dec.b1     = r_s1.data[15:8];
                dec.b2     = r_s1.data[7:0];
                dec.b3     = r_s1.data[31:24];
                dec.nbytes = 3'd4;
            end
            tga_pkg::FMT_GRAY8: begin
                dec.b0     = r_s1.data[7:0];
                dec.nbytes = 3'd1;
            end
            tga_pkg::FMT_GRAY16: begin
                dec.b0     = r_s1.data[7:0];
                dec.b1     = r_s1.data[15:8];
                dec.nbytes = 3'd2;
            end
            default: begin
                dec.b0 = r_s1.data[23:16];
                dec.b1 = r_s1.data[15:8];
                dec.b2 = r_s1.data[7:0];
            end
        endcase
    end

    // output queue
    assign o_empty = (r_cnt == '0);
    assign o_pix   = r_oq[r_rp];
    assign oq_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (r_s1_valid) begin
            n_wp = (r_wp == tga_pkg::OUTQ_PW'(tga_pkg::OUTQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (oq_pop) begin
            n_rp = (r_rp == tga_pkg::OUTQ_PW'(tga_pkg::OUTQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (r_s1_valid && !oq_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (oq_pop && !r_s1_valid) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_oq[r_wp] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_wp       <= '0;
            r_rp       <= '0;
            r_cnt      <= '0;
        end else begin
            r_s1_valid <= o_q_pop && !i_q_data.wr;
            r_wp       <= n_wp;
            r_rp       <= n_rp;
            r_cnt      <= n_cnt;
        end
    end

`ifndef SYNTHESIS
    a_oq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_cnt < tga_pkg::OUTQ_CW'(tga_pkg::OUTQ_DEPTH)))
        else $error("decoded pixel arrives at a full output queue");
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_q_data.wr) |=> !r_s1_valid)
        else $error("palette write produced a result");
`endif

endmodule

`default_nettype wire

/* design/tga_rle_pixel_decoder_unit.sv */
// Top level of the Targa run-length pixel decoder.
// Depends on tga_pkg, tga_fe, tga_cmdq and tga_be.
//
// Usage:
//   Input channel: drive the item on i_func, i_data_byte, i_palette_index and
//   i_palette_color with push high; the transfer happens at a rising edge
//   where full is low. A stream byte (i_func low) feeds the packet parser; a
//   palette write (i_func high) updates one palette entry, in order with the
//   pixels around it.
//   Result channel: while empty is low the oldest result sits on the o_ ports;
//   raise pop to take it. Each result is one decoded pixel with its repeat
//   count and a flag on the pixel that reaches the image total.
//   Configuration: write pixel format, RLE enable and pixel total through
//   i_cfg_we, i_cfg_idx and i_cfg_data while no item is in flight.
//   Timing: one item per cycle while full is low. A result becomes visible
//   once the finished pixel has passed the command queue, the stage-1
//   register with its registered palette read, and the output queue.
//   Stalls: if pop stays low the output queue fills, the back end stops
//   draining the command queue, and full rises once it is full as well.
//   Reset: synchronous, active low; clears packet state, pixel count and
//   queues and restores register defaults. Palette contents are kept and are
//   undefined until written.
`default_nettype none

module tga_rle_pixel_decoder_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [24:0] i_cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_func,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [7:0]  i_palette_index,
    input  wire logic [23:0] i_palette_color,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_out_byte0,
    output logic [7:0]       o_out_byte1,
    output logic [7:0]       o_out_byte2,
    output logic [7:0]       o_out_byte3,
    output logic [2:0]       o_pixel_bytes,
    output logic [7:0]       o_repeat_count,
    output logic             o_last_pixel
);

    logic          cmd_valid;
    tga_pkg::t_cmd cmd_in;
    tga_pkg::t_cmd cmd_out;
    logic          cmdq_empty;
    logic          cmdq_pop;
    tga_pkg::t_pix pix;

    // Front end: parse packets, gather bytes, count pixels
    tga_fe u_fe (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_push          (push),
        .i_qfull         (full),
        .i_func          (i_func),
        .i_data_byte     (i_data_byte),
        .i_palette_index (i_palette_index),
        .i_palette_color (i_palette_color),
        .o_cmd_valid     (cmd_valid),
        .o_cmd           (cmd_in)
    );

    // Hold commands so that each side stalls on its own
    tga_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_data  (cmd_in),
        .o_full  (full),
        .i_pop   (cmdq_pop),
        .o_empty (cmdq_empty),
        .o_data  (cmd_out)
    );

    // Back end: palette, format assembly, result queue
    tga_be u_be (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (cmdq_empty),
        .i_q_data  (cmd_out),
        .o_q_pop   (cmdq_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_pix     (pix)
    );

    assign o_out_byte0    = pix.b0;
    assign o_out_byte1    = pix.b1;
    assign o_out_byte2    = pix.b2;
    assign o_out_byte3    = pix.b3;
    assign o_pixel_bytes  = pix.nbytes;
    assign o_repeat_count = pix.rep;
    assign o_last_pixel   = pix.last;

endmodule

`default_nettype wire
